@@ hdl/hashed_bucket_find_replace_assert.svh @@
// assertion macros for the bucket lookup block
// the user module must provide clk and rst_n
`ifndef HASHED_BUCKET_FIND_REPLACE_ASSERT_SVH
`define HASHED_BUCKET_FIND_REPLACE_ASSERT_SVH

// same-cycle implication
`define HBFR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hbfr check failed");

// next-cycle implication
`define HBFR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hbfr check failed");

`endif

@@ hdl/hbfr_pkg.sv @@
package hbfr_pkg;

    localparam int MAX_SIZE_BITS_DEF = 10;
    localparam int ROW_BYTES = 16;
    localparam int SIZE_W = 4;
    localparam int SIZE_BITS_RESET = 10;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE = 3'b010,
        ST_EVAL = 3'b100
    } state_t;

    typedef struct packed {
        logic clear;
        logic accept;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
    } sts_t;

endpackage

@@ hdl/hbfr_ram.sv @@
module hbfr_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 1024,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/hbfr_ctrl.sv @@
module hbfr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  hbfr_pkg::sts_t    sts,
    output hbfr_pkg::cmd_t    cmd
);

    hbfr_pkg::state_t state_reg;
    hbfr_pkg::state_t state_next;
    logic out_valid_reg;
    logic out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            hbfr_pkg::ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = hbfr_pkg::ST_IDLE;
                end
            end
            hbfr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = hbfr_pkg::ST_EVAL;
                end
            end
            hbfr_pkg::ST_EVAL:
            begin
                // result register must be free or emptying this cycle
                cmd.commit = !out_valid_reg || out_ready;
                if (cmd.commit)
                begin
                    state_next = hbfr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hbfr_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hbfr_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ hdl/hbfr_datapath.sv @@
module hbfr_datapath #(
    parameter int MAX_SIZE_BITS = hbfr_pkg::MAX_SIZE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [hbfr_pkg::SIZE_W-1:0] cfg_wdata,
    input  logic [1:0]                  op,
    input  logic [31:0]                 context_req,
    input  logic [11:0]                 row_addr,
    input  logic [3:0]                  byte_pos,
    input  logic [7:0]                  value,
    input  hbfr_pkg::cmd_t              cmd,
    output hbfr_pkg::sts_t              sts,
    output logic [11:0]                 row_index,
    output logic                        hit,
    output logic [7:0]                  read_data
);

    localparam int SW = hbfr_pkg::SIZE_W;
    localparam int ROW_W = MAX_SIZE_BITS + 2;
    localparam int BANK_DEPTH = 1 << MAX_SIZE_BITS;
    localparam int BANK_AW = (MAX_SIZE_BITS < 1) ? 1 : MAX_SIZE_BITS;
    localparam int ROW_BITS = hbfr_pkg::ROW_BYTES * 8;
    localparam int SIZE_RST = (hbfr_pkg::SIZE_BITS_RESET > MAX_SIZE_BITS) ?
                              MAX_SIZE_BITS : hbfr_pkg::SIZE_BITS_RESET;

    // configuration
    logic [SW-1:0] size_bits_reg;
    logic [SW-1:0] size_bits_next;

    always_comb
    begin
        size_bits_next = size_bits_reg;
        if (cfg_we)
        begin
            if (int'(cfg_wdata) > MAX_SIZE_BITS)
            begin
                size_bits_next = SW'(MAX_SIZE_BITS);
            end
            else
            begin
                size_bits_next = cfg_wdata;
            end
        end
    end

    // clear sweep, one row per bank each cycle
    logic [BANK_AW-1:0] clear_cnt_reg;
    logic [BANK_AW-1:0] clear_cnt_next;

    assign clear_cnt_next = cmd.clear ? clear_cnt_reg + 1'b1 : clear_cnt_reg;
    assign sts.clear_last = (clear_cnt_reg == BANK_AW'(BANK_DEPTH - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_bits_reg <= SW'(SIZE_RST);
            clear_cnt_reg <= '0;
        end
        else
        begin
            size_bits_reg <= size_bits_next;
            clear_cnt_reg <= clear_cnt_next;
        end
    end

    // accept stage: home or given row, check byte and bank read address
    logic [31:0]        row_mask;
    logic [ROW_W-1:0]   home_row;
    logic [ROW_W-1:0]   phys_row;
    logic [ROW_W-1:0]   sel_row;
    logic [7:0]         chk_byte;
    logic [BANK_AW-1:0] rd_addr;

    assign row_mask = ~(32'hFFFF_FFFF << ({1'b0, size_bits_reg} + 5'd2));
    assign home_row = ROW_W'(context_req & row_mask);
    assign phys_row = ROW_W'({20'd0, row_addr});
    assign sel_row = (op == hbfr_pkg::OP_LOOKUP) ? home_row : phys_row;
    assign chk_byte = 8'(context_req >> size_bits_reg);
    assign rd_addr = BANK_AW'(sel_row >> 2);

    logic [1:0]       op_reg;
    logic [ROW_W-1:0] row_reg;
    logic [11:0]      addr_reg;
    logic [7:0]       chk_reg;
    logic [3:0]       pos_reg;
    logic [7:0]       val_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg <= op;
            row_reg <= sel_row;
            addr_reg <= row_addr;
            chk_reg <= chk_byte;
            pos_reg <= byte_pos;
            val_reg <= value;
        end
    end

    // four banks on the low two row bits
    logic [ROW_BITS-1:0] bank_q [4];
    logic [3:0]          bank_we;
    logic [BANK_AW-1:0]  wr_addr;
    logic [ROW_BITS-1:0] wr_data;

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        hbfr_ram #(
            .WIDTH (ROW_BITS),
            .DEPTH (BANK_DEPTH),
            .AW    (BANK_AW)
        ) u_bank (
            .clk   (clk),
            .we    (bank_we[b]),
            .waddr (wr_addr),
            .wdata (wr_data),
            .re    (cmd.accept),
            .raddr (rd_addr),
            .rdata (bank_q[b])
        );
    end

    // eval stage
    logic [1:0]          home_bank;
    logic [ROW_BITS-1:0] probe0;
    logic [ROW_BITS-1:0] probe1;
    logic [ROW_BITS-1:0] probe2;
    logic                look_hit;
    logic [1:0]          probe_sel;
    logic [1:0]          hit_bank;
    logic [ROW_W-1:0]    look_row;
    logic [ROW_BITS-1:0] patched_row;
    logic [7:0]          byte_rd;
    logic                is_lookup;
    logic                is_write;
    logic                is_read;

    assign home_bank = row_reg[1:0];
    assign probe0 = bank_q[home_bank];
    assign probe1 = bank_q[home_bank ^ 2'd1];
    assign probe2 = bank_q[home_bank ^ 2'd2];
    assign is_lookup = (op_reg == hbfr_pkg::OP_LOOKUP);
    assign is_write = (op_reg == hbfr_pkg::OP_WRITE);
    assign is_read = (op_reg == hbfr_pkg::OP_READ);

    always_comb
    begin
        look_hit = 1'b1;
        priority if (probe0[7:0] == chk_reg)
        begin
            probe_sel = 2'd0;
        end
        else if (probe1[7:0] == chk_reg)
        begin
            probe_sel = 2'd1;
        end
        else if (probe2[7:0] == chk_reg)
        begin
            probe_sel = 2'd2;
        end
        else
        begin
            // victim: lowest priority byte; ties go to home, and between the other two to the third probe
            look_hit = 1'b0;
            priority if (probe0[15:8] <= probe1[15:8] && probe0[15:8] <= probe2[15:8])
            begin
                probe_sel = 2'd0;
            end
            else if (probe1[15:8] < probe2[15:8])
            begin
                probe_sel = 2'd1;
            end
            else
            begin
                probe_sel = 2'd2;
            end
        end
    end

    assign hit_bank = home_bank ^ probe_sel;
    assign look_row = {row_reg[ROW_W-1:2], hit_bank};
    assign byte_rd = probe0[{pos_reg, 3'b000} +: 8];

    always_comb
    begin
        patched_row = probe0;
        patched_row[{pos_reg, 3'b000} +: 8] = val_reg;
    end

    always_comb
    begin
        priority if (cmd.clear)
        begin
            wr_data = '0;
            wr_addr = clear_cnt_reg;
        end
        else if (is_lookup)
        begin
            wr_data = ROW_BITS'(chk_reg);
            wr_addr = BANK_AW'(row_reg >> 2);
        end
        else
        begin
            wr_data = patched_row;
            wr_addr = BANK_AW'(row_reg >> 2);
        end
    end

    for (genvar b = 0; b < 4; b++)
    begin : g_we
        assign bank_we[b] = cmd.clear
            || (cmd.commit && is_lookup && !look_hit && hit_bank == 2'(b))
            || (cmd.commit && is_write && home_bank == 2'(b));
    end

    // result register
    logic [11:0] row_index_reg;
    logic        hit_reg;
    logic [7:0]  read_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            row_index_reg <= is_lookup ? 12'(32'(look_row)) : addr_reg;
            hit_reg <= is_lookup && look_hit;
            read_data_reg <= is_read ? byte_rd : 8'd0;
        end
    end

    assign row_index = row_index_reg;
    assign hit = hit_reg;
    assign read_data = read_data_reg;

endmodule

@@ hdl/hashed_bucket_find_replace.sv @@
// channel  | handshake            | payload
// ---------+----------------------+--------------------------------------------
// in       | in_valid / in_ready  | op, context_req, row_addr, byte_pos, value
// out      | out_valid / out_ready| row_index, hit, read_data
// cfg      | cfg_we               | cfg_wdata (size_bits)
//
// each word is read from the banks at accept, then compared and written back in the eval state
// the table is four banks on the low row bits, so the three probe rows read at once
// after reset a clear sweep zeroes every row of every bank with in_ready low
// a finished word waits in the result register; one more word may be accepted
// and then holds in the eval state until the result register frees
module hashed_bucket_find_replace #(
    parameter int MAX_SIZE_BITS = hbfr_pkg::MAX_SIZE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [hbfr_pkg::SIZE_W-1:0] cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  op,
    input  logic [31:0]                 context_req,
    input  logic [11:0]                 row_addr,
    input  logic [3:0]                  byte_pos,
    input  logic [7:0]                  value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [11:0]                 row_index,
    output logic                        hit,
    output logic [7:0]                  read_data
);

    hbfr_pkg::cmd_t cmd;
    hbfr_pkg::sts_t sts;

    hbfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    hbfr_datapath #(
        .MAX_SIZE_BITS (MAX_SIZE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .op          (op),
        .context_req (context_req),
        .row_addr    (row_addr),
        .byte_pos    (byte_pos),
        .value       (value),
        .cmd         (cmd),
        .sts         (sts),
        .row_index   (row_index),
        .hit         (hit),
        .read_data   (read_data)
    );

endmodule

@@ hdl/hbfr_checker.sv @@
`include "hashed_bucket_find_replace_assert.svh"

module hbfr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [11:0] row_index,
    input logic        hit,
    input logic [7:0]  read_data
);

    // one word in flight: ready drops right after an accept
    `HBFR_ASSERT_NEXT(a_ready_drops, in_valid && in_ready, !in_ready)

    // a new result only appears right after the input was closed
    `HBFR_ASSERT_IMPL(a_result_after_work, $rose(out_valid), !$past(in_ready))

    // a hit comes only from a lookup, which never returns read data
    `HBFR_ASSERT_IMPL(a_hit_no_data, out_valid && hit, read_data == 8'd0)

    // stalled result holds
    `HBFR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(row_index) && $stable(hit) && $stable(read_data))

endmodule

bind hashed_bucket_find_replace hbfr_checker u_hbfr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .row_index (row_index),
    .hit       (hit),
    .read_data (read_data)
);
